// ===== hdl/json_string_unescape_unit_defines.svh =====
// assertion macros used by the checker file of the json string unescape unit
`ifndef JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/jsu_pkg.sv =====
// shared types and constants of the json string unescape unit
package jsu_pkg;

    // decoder modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BODY  = 2'd1;
    localparam logic [1:0] MODE_ESC   = 2'd2;
    localparam logic [1:0] MODE_HEX   = 2'd3;

    // most result requests that one input byte can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  hex_count;
        logic [15:0] code_acc;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]               cnt;
        logic [MAX_RES-1:0][7:0]  bytes;
        logic                     bval;
        logic                     done;
    } dec_res_t;

endpackage

// ===== hdl/jsu_decoder.sv =====
// combinational per-byte decode step: escape handling, hex gathering, utf-8 split
module jsu_decoder
(
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  jsu_pkg::dec_state_t cur,
    output jsu_pkg::dec_state_t nxt,
    output jsu_pkg::dec_res_t   res
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        begin
            v = 4'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = 4'(c - 8'h30);
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = 4'(c - 8'h57);
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v = 4'(c - 8'h37);
            end
            return v;
        end
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                CH_QUOTE: r = CH_QUOTE;
                CH_SLASH: r = CH_SLASH;
                CH_BSL:   r = CH_BSL;
                8'h62:    r = 8'h08;
                8'h66:    r = 8'h0C;
                8'h6E:    r = 8'h0A;
                8'h72:    r = 8'h0D;
                8'h74:    r = 8'h09;
                default:  r = 8'h00;
            endcase
            return r;
        end
    endfunction

    localparam jsu_pkg::dec_state_t IDLE_ST = '{jsu_pkg::MODE_START, 2'd0, 16'd0};

    logic        body_path;
    logic [15:0] acc_shift;

    assign body_path = (cur.mode == jsu_pkg::MODE_BODY) ||
                       ((cur.mode == jsu_pkg::MODE_START) && (in_byte != CH_QUOTE));
    assign acc_shift = {cur.code_acc[11:0], hex_value(in_byte)};

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (body_path)
        begin
            if (in_byte == CH_QUOTE)
            begin
                res.cnt  = 2'd1;
                res.done = 1'b1;
                nxt      = IDLE_ST;
            end
            else if (in_byte == CH_BSL)
            begin
                if (in_last)
                begin
                    res.cnt  = 2'd1;
                    res.done = 1'b1;
                    nxt      = IDLE_ST;
                end
                else
                begin
                    nxt.mode = jsu_pkg::MODE_ESC;
                end
            end
            else
            begin
                res.cnt      = 2'd1;
                res.bytes[0] = in_byte;
                res.bval     = 1'b1;
                res.done     = in_last;
                nxt.mode     = jsu_pkg::MODE_BODY;
                if (in_last)
                begin
                    nxt = IDLE_ST;
                end
            end
        end
        else
        begin
            case (cur.mode)
                jsu_pkg::MODE_START:
                begin
                    // opening quote
                    if (in_last)
                    begin
                        res.cnt  = 2'd1;
                        res.done = 1'b1;
                        nxt      = IDLE_ST;
                    end
                    else
                    begin
                        nxt.mode = jsu_pkg::MODE_BODY;
                    end
                end
                jsu_pkg::MODE_ESC:
                begin
                    if (in_byte == CH_U)
                    begin
                        if (in_last)
                        begin
                            res.cnt  = 2'd1;
                            res.done = 1'b1;
                            nxt      = IDLE_ST;
                        end
                        else
                        begin
                            nxt.mode      = jsu_pkg::MODE_HEX;
                            nxt.hex_count = 2'd0;
                            nxt.code_acc  = 16'd0;
                        end
                    end
                    else
                    begin
                        res.cnt      = 2'd1;
                        res.bytes[0] = escape_map(in_byte);
                        res.bval     = 1'b1;
                        res.done     = in_last;
                        nxt.mode     = jsu_pkg::MODE_BODY;
                        if (in_last)
                        begin
                            nxt = IDLE_ST;
                        end
                    end
                end
                default:
                begin
                    if (cur.hex_count == 2'd3)
                    begin
                        res.bval = 1'b1;
                        res.done = in_last;
                        if (acc_shift < 16'h0080)
                        begin
                            res.cnt      = 2'd1;
                            res.bytes[0] = acc_shift[7:0];
                        end
                        else if (acc_shift < 16'h0800)
                        begin
                            res.cnt      = 2'd2;
                            res.bytes[0] = {3'b110, acc_shift[10:6]};
                            res.bytes[1] = {2'b10, acc_shift[5:0]};
                        end
                        else
                        begin
                            res.cnt      = 2'd3;
                            res.bytes[0] = {4'b1110, acc_shift[15:12]};
                            res.bytes[1] = {2'b10, acc_shift[11:6]};
                            res.bytes[2] = {2'b10, acc_shift[5:0]};
                        end
                        nxt.mode      = jsu_pkg::MODE_BODY;
                        nxt.hex_count = 2'd0;
                        nxt.code_acc  = 16'd0;
                        if (in_last)
                        begin
                            nxt = IDLE_ST;
                        end
                    end
                    else if (in_last)
                    begin
                        // escape cut short: dropped
                        res.cnt  = 2'd1;
                        res.done = 1'b1;
                        nxt      = IDLE_ST;
                    end
                    else
                    begin
                        nxt.hex_count = cur.hex_count + 2'd1;
                        nxt.code_acc  = acc_shift;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/json_string_unescape_unit.sv =====
// top level of the json string unescape unit: input register, decode, result buffer
//
// usage
//   s_tvalid/s_tready/s_tdata/s_tlast carry raw bytes of a json string literal;
//   s_tlast marks the last byte of the input buffer.
//   m_tvalid/m_tready/m_tdata/m_tuser/m_tlast carry decoded bytes; m_tuser is high
//   when m_tdata holds a decoded byte, m_tlast marks the final request of a string.
//   a closing quote or a cut escape gives one request with m_tuser low, m_tdata zero.
// data path: an accepted byte sits in the input register, then is decoded into
//   the result buffer once that buffer can take it and offers its first result
//   request from there.
// throughput: one input byte per cycle while each byte gives at most one result and
//   m_tready stays high; a \u escape that expands to two or three utf-8 bytes holds
//   the result buffer until the single output port has drained all of them.
// reset: decoder returns to waiting for an optional opening quote, both
//   registers are emptied.
// stall: when m_tready is low the result buffer holds and the input register
//   fills, after which s_tready drops; no request is lost or repeated.
module json_string_unescape_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] byte_valid
    output logic       m_tlast    // string_done
);

    // input register
    logic       in_v_reg;
    logic [7:0] in_b_reg;
    logic       in_l_reg;

    // decoder state
    jsu_pkg::dec_state_t st_reg;
    jsu_pkg::dec_state_t st_next;
    jsu_pkg::dec_res_t   dec_res;

    // result buffer: up to three pending result requests
    logic [jsu_pkg::MAX_RES-1:0][7:0] rb_reg;
    logic [1:0] rem_reg;
    logic [1:0] pos_reg;
    logic       bval_reg;
    logic       done_reg;

    logic load_ok;
    logic consume;
    logic out_take;

    jsu_decoder u_dec
    (
        .in_byte (in_b_reg),
        .in_last (in_l_reg),
        .cur     (st_reg),
        .nxt     (st_next),
        .res     (dec_res)
    );

    assign out_take = m_tvalid && m_tready;
    // buffer can take a fresh item when empty or its last request leaves now
    assign load_ok  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_tready);
    assign consume  = in_v_reg && load_ok;
    assign s_tready = !in_v_reg || consume;

    assign m_tvalid = (rem_reg != 2'd0);
    assign m_tdata  = rb_reg[pos_reg];
    assign m_tuser  = bval_reg;
    assign m_tlast  = done_reg && (rem_reg == 2'd1);

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_b_reg <= s_tdata;
            in_l_reg <= s_tlast;
        end
    end

    // decoder state and result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '{jsu_pkg::MODE_START, 2'd0, 16'd0};
            rem_reg  <= 2'd0;
            pos_reg  <= 2'd0;
            bval_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (consume)
        begin
            st_reg   <= st_next;
            rem_reg  <= dec_res.cnt;
            pos_reg  <= 2'd0;
            bval_reg <= dec_res.bval;
            done_reg <= dec_res.done;
        end
        else if (out_take)
        begin
            rem_reg <= rem_reg - 2'd1;
            if (rem_reg != 2'd1)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            rb_reg <= dec_res.bytes;
        end
    end

endmodule

// ===== hdl/jsu_checker.sv =====
// port-level checks of the json string unescape unit and their bind
`include "json_string_unescape_unit_defines.svh"

module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled result request stays offered
    `JSU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    // a request without a decoded byte carries zero data
    `JSU_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser, m_tdata == 8'd0, "non-zero empty result")
    // a request without a decoded byte always ends a string
    `JSU_ASSERT_NOW(a_empty_ends, m_tvalid && !m_tuser, m_tlast, "empty result without end")
    // with the result side empty the input side is always open
    `JSU_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty output")
    // a stalled result request keeps its contents
    `JSU_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // input valid is watched only through the ready it sees
    logic unused_in;
    assign unused_in = s_tvalid;

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
